// File: src/assert_macros.svh
// Assertion macros used by the top-level RTL file of the harmonic exciter
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset
`define HE_ASSERT_IMP(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication
`define HE_ASSERT_NXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// File: src/he_pkg.sv
// Package: widths, register indexes, state type and unit handshake structs
`default_nettype none

package he_pkg;

    // Sample format and internal Q.24 fixed point
    localparam int SAMPLE_BITS = 16;
    localparam int FRAC        = 24;
    localparam int IN_SHIFT    = FRAC + 1 - SAMPLE_BITS;
    localparam int XW          = FRAC + 1;         // scaled input, +-2^24
    localparam int LPW         = 32;               // lowpass state
    localparam int MW          = 34;               // multiplicand
    localparam int CW          = 17;               // serial coefficient
    localparam int PW          = MW + CW;          // product
    localparam int NMW         = 38;               // numerator magnitude before scaling
    localparam int NW          = NMW + 16;         // divider numerator
    localparam int DW          = 31;               // divider denominator
    localparam int YW          = 44;               // mix sum
    localparam int ONE_Q       = 1 << FRAC;
    localparam int SMAX        = (1 << (SAMPLE_BITS - 1)) - 1;
    localparam int MCNT_W      = $clog2(CW + 1);
    localparam int DCNT_W      = $clog2(NW + 1);

    // Configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam int KW         = 13;

    localparam logic [CFG_IDX_W-1:0] REG_LP_POLE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_GAIN = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_SHAPER_K  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_MIX_GAIN  = CFG_IDX_W'(3);

    localparam logic [15:0]   RST_LP_POLE   = 16'd55240;
    localparam logic [15:0]   RST_CLIP_GAIN = 16'd511;
    localparam logic [KW-1:0] RST_SHAPER_K  = KW'(512);
    localparam logic [15:0]   RST_MIX_GAIN  = 16'd128;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_LP1A,
        S_LP1B,
        S_CLIP,
        S_KAX,
        S_NUM,
        S_DIV,
        S_LP2A,
        S_LP2B,
        S_MIX,
        S_PUSH
    } t_state;

    typedef struct packed {
        logic          start;
        logic [MW-1:0] a;       // signed multiplicand
        logic [CW-1:0] b;       // unsigned coefficient
    } t_mul_req;

    typedef struct packed {
        logic          start;
        logic [NW-1:0] num;
        logic [DW-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

endpackage

`default_nettype wire

// File: src/he_if.sv
// Stream and configuration interfaces of the harmonic exciter
`default_nettype none

interface he_in_if import he_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface he_out_if import he_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

interface he_cfg_if import he_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: src/he_mul.sv
// Bit-serial signed-by-unsigned multiplier, coefficient MSB first
`default_nettype none

module he_mul import he_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_mul_req          i_req,
    output t_unit_stat             o_stat,
    output logic signed [PW-1:0]   o_prod
);

    logic                 r_run, r_done;
    logic [MCNT_W-1:0]    r_cnt;
    logic signed [MW-1:0] r_a;
    logic [CW-1:0]        r_b;
    logic signed [PW-1:0] r_acc;
    logic signed [PW-1:0] n_acc;

    // shift-and-add step
    always_comb begin
        n_acc = (r_acc <<< 1);
        if (r_b[CW-1]) begin
            n_acc = n_acc + {{CW{r_a[MW-1]}}, r_a};
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run <= 1'b1;
                r_cnt <= MCNT_W'(CW);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == MCNT_W'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // operands and accumulator
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a   <= $signed(i_req.a);
            r_b   <= i_req.b;
            r_acc <= '0;
        end else if (r_run) begin
            r_acc <= n_acc;
            r_b   <= {r_b[CW-2:0], 1'b0};
        end
    end

    assign o_prod = r_acc;
    assign o_stat = '{busy: r_run, done: r_done};

endmodule

`default_nettype wire

// File: src/he_div.sv
// Restoring unsigned divider, one quotient bit per cycle
`default_nettype none

module he_div import he_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_div_req   i_req,
    output t_unit_stat      o_stat,
    output logic [DW-1:0]   o_quot
);

    logic              r_run, r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic [NW-1:0]     r_q;
    logic [DW-1:0]     r_den;
    logic [DW-1:0]     r_rem;
    logic [DW:0]       w_trial;
    logic [DW:0]       w_diff;
    logic              w_bit;

    // trial subtract
    always_comb begin
        w_trial = {r_rem, r_q[NW-1]};
        w_diff  = w_trial - {1'b0, r_den};
        w_bit   = (w_trial >= {1'b0, r_den});
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run <= 1'b1;
                r_cnt <= DCNT_W'(NW);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DCNT_W'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.num;
            r_den <= i_req.den;
            r_rem <= '0;
        end else if (r_run) begin
            r_rem <= w_bit ? w_diff[DW-1:0] : w_trial[DW-1:0];
            r_q   <= {r_q[NW-2:0], w_bit};
        end
    end

    assign o_quot = r_q[DW-1:0];
    assign o_stat = '{busy: r_run, done: r_done};

endmodule

`default_nettype wire

// File: src/harmonic_exciter.sv
// Top level: sequencer, config registers and datapath of the harmonic exciter
//
//   port    dir  role                    payload
//   i_in    in   sample stream, sink     sample_in  (signed 16)
//   o_out   out  sample stream, source   sample_out (signed 16)
//   i_cfg   in   register writes, sink   index (8), data (16)
//
// Each sample runs eight bit-serial multiplies in the shared multiplier
// plus a 54-step restoring divide for the shaper.
// One sample is in work at a time; i_in.ready is high only while idle.
// The output register frees the sequencer: a result waits there while the
// next sample is taken; a second result waits in the sequencer if needed.
// Reset (i_rst_n low, synchronous) clears both lowpass states and loads the
// register defaults. Config writes are always accepted.
`default_nettype none
`include "assert_macros.svh"

module harmonic_exciter import he_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    he_in_if.sink      i_in,
    he_out_if.source   o_out,
    he_cfg_if.sink     i_cfg
);

    t_state r_st, n_st;
    logic   r_go;

    // configuration registers
    logic [15:0]   r_lp_pole, r_clip_gain, r_mix_gain;
    logic [KW-1:0] r_shaper_k;

    // state and working registers
    logic signed [LPW-1:0] r_lp1, r_lp2;
    logic signed [XW-1:0]  r_x;
    logic signed [MW-1:0]  r_hp;
    logic signed [XW:0]    r_c;
    logic [DW-1:0]         r_den;
    logic                  r_neg;
    logic [NMW-1:0]        r_nmag;
    logic signed [LPW-1:0] r_sh;
    logic signed [PW-1:0]  r_acc;
    logic signed [SAMPLE_BITS-1:0] r_res;
    logic                  r_ov;
    logic signed [SAMPLE_BITS-1:0] r_od;

    // units
    t_mul_req              w_mreq;
    t_unit_stat            w_mstat;
    logic signed [PW-1:0]  w_prod;
    t_div_req              w_dreq;
    t_unit_stat            w_dstat;
    logic [DW-1:0]         w_quot;

    logic [CW-1:0]         w_omp;
    logic [XW-1:0]         w_ax;
    logic signed [PW-1:0]  w_nl;
    logic signed [PW-1:0]  w_t;
    logic signed [YW-1:0]  w_y;
    logic signed [YW-1:0]  w_o;
    logic signed [SAMPLE_BITS-1:0] w_sat;
    logic                  w_push;

    he_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mreq),
        .o_stat  (w_mstat),
        .o_prod  (w_prod)
    );

    he_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_dreq),
        .o_stat  (w_dstat),
        .o_quot  (w_quot)
    );

    // config writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lp_pole   <= RST_LP_POLE;
            r_clip_gain <= RST_CLIP_GAIN;
            r_shaper_k  <= RST_SHAPER_K;
            r_mix_gain  <= RST_MIX_GAIN;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_LP_POLE:   r_lp_pole   <= i_cfg.data;
                REG_CLIP_GAIN: r_clip_gain <= i_cfg.data;
                REG_SHAPER_K:  r_shaper_k  <= i_cfg.data[KW-1:0];
                REG_MIX_GAIN:  r_mix_gain  <= i_cfg.data;
                default:       ;
            endcase
        end
    end

    // shared arithmetic helpers
    always_comb begin
        w_omp = CW'(17'h10000) - {1'b0, r_lp_pole};
        w_ax  = r_x[XW-1] ? XW'(-r_x) : XW'(r_x);
        w_nl  = (r_acc + w_prod + PW'(32768)) >>> 16;
        w_t   = w_prod >>> 8;
        w_y   = {{(YW-XW){r_x[XW-1]}}, r_x} + w_t[YW-1:0];
        w_o   = (w_y + YW'(1 << (IN_SHIFT - 1))) >>> IN_SHIFT;
        if (w_o > $signed(YW'(SMAX))) begin
            w_sat = SAMPLE_BITS'(SMAX);
        end else if (w_o < -$signed(YW'(SMAX)) - 1) begin
            w_sat = SAMPLE_BITS'(-SMAX - 1);
        end else begin
            w_sat = w_o[SAMPLE_BITS-1:0];
        end
    end

    assign w_push = (r_st == S_PUSH) && (!r_ov || o_out.ready);

    // next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE: if (i_in.valid) n_st = S_LP1A;
            S_LP1A: if (w_mstat.done) n_st = S_LP1B;
            S_LP1B: if (w_mstat.done) n_st = S_CLIP;
            S_CLIP: if (w_mstat.done) n_st = S_KAX;
            S_KAX:  if (w_mstat.done) n_st = S_NUM;
            S_NUM:  if (w_mstat.done) n_st = S_DIV;
            S_DIV:  if (w_dstat.done) n_st = S_LP2A;
            S_LP2A: if (w_mstat.done) n_st = S_LP2B;
            S_LP2B: if (w_mstat.done) n_st = S_MIX;
            S_MIX:  if (w_mstat.done) n_st = S_PUSH;
            S_PUSH: if (w_push) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    // unit requests
    always_comb begin
        w_mreq       = '0;
        w_mreq.start = !r_go;
        w_dreq.start = 1'b0;
        w_dreq.num   = {r_nmag, 16'd0};
        w_dreq.den   = r_den;
        unique case (r_st)
            S_LP1A: begin
                w_mreq.a = {{(MW-XW){r_x[XW-1]}}, r_x};
                w_mreq.b = w_omp;
            end
            S_LP1B: begin
                w_mreq.a = {{(MW-LPW){r_lp1[LPW-1]}}, r_lp1};
                w_mreq.b = {1'b0, r_lp_pole};
            end
            S_CLIP: begin
                w_mreq.a = r_hp;
                w_mreq.b = {1'b0, r_clip_gain};
            end
            S_KAX: begin
                w_mreq.a = {{(MW-XW){1'b0}}, w_ax};
                w_mreq.b = CW'(r_shaper_k);
            end
            S_NUM: begin
                w_mreq.a = {{(MW-XW-1){r_c[XW]}}, r_c};
                w_mreq.b = CW'(r_shaper_k) + CW'(256);
            end
            S_LP2A: begin
                w_mreq.a = {{(MW-LPW){r_sh[LPW-1]}}, r_sh};
                w_mreq.b = w_omp;
            end
            S_LP2B: begin
                w_mreq.a = {{(MW-LPW){r_lp2[LPW-1]}}, r_lp2};
                w_mreq.b = {1'b0, r_lp_pole};
            end
            S_MIX: begin
                w_mreq.a = r_hp;
                w_mreq.b = {1'b0, r_mix_gain};
            end
            S_DIV: begin
                w_mreq.start = 1'b0;
                w_dreq.start = !r_go;
            end
            default: w_mreq.start = 1'b0;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= S_IDLE;
            r_go  <= 1'b0;
            r_ov  <= 1'b0;
            r_lp1 <= '0;
            r_lp2 <= '0;
        end else begin
            r_st <= n_st;
            if (n_st != r_st) begin
                r_go <= 1'b0;
            end else if (w_mreq.start || w_dreq.start) begin
                r_go <= 1'b1;
            end
            if (w_push) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            if (r_st == S_LP1B && w_mstat.done) r_lp1 <= w_nl[LPW-1:0];
            if (r_st == S_LP2B && w_mstat.done) r_lp2 <= w_nl[LPW-1:0];
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_push) r_od <= r_res;
        if (r_st == S_IDLE && i_in.valid) begin
            r_x <= {i_in.sample_in, {IN_SHIFT{1'b0}}};
        end
        if (r_st == S_DIV && w_dstat.done) begin
            r_sh <= r_neg ? -$signed({1'b0, w_quot}) : $signed({1'b0, w_quot});
        end
        if (w_mstat.done) begin
            case (r_st)
                S_LP1A, S_LP2A: r_acc <= w_prod;
                S_LP1B: r_hp <= {{(MW-XW){r_x[XW-1]}}, r_x} - w_nl[MW-1:0];
                S_LP2B: r_hp <= {{(MW-LPW){r_sh[LPW-1]}}, r_sh} - w_nl[MW-1:0];
                S_CLIP: begin
                    if (w_t > $signed(PW'(ONE_Q))) begin
                        r_c <= (XW+1)'(ONE_Q);
                    end else if (w_t < -$signed(PW'(ONE_Q))) begin
                        r_c <= -$signed((XW+1)'(ONE_Q));
                    end else begin
                        r_c <= w_t[XW:0];
                    end
                end
                S_KAX: r_den <= DW'(ONE_Q) + w_prod[DW+7:8];
                S_NUM: begin
                    r_neg  <= w_prod[PW-1];
                    r_nmag <= w_prod[PW-1] ? NMW'(-w_prod) : NMW'(w_prod);
                end
                S_MIX: r_res <= w_sat;
                default: ;
            endcase
        end
    end

    assign i_in.ready       = (r_st == S_IDLE);
    assign o_out.valid      = r_ov;
    assign o_out.sample_out = r_od;

    // checks
    `HE_ASSERT_NXT(a_start, i_in.valid && i_in.ready, r_st == S_LP1A,
        "accepted sample did not start the sequence")
    `HE_ASSERT_IMP(a_div_done, w_dstat.done, r_st == S_DIV,
        "divider finished outside the divide step")
    `HE_ASSERT_IMP(a_units_excl, 1'b1, !(w_mstat.busy && w_dstat.busy),
        "multiplier and divider running together")
    `HE_ASSERT_NXT(a_push, w_push, o_out.valid && o_out.sample_out == $past(r_res),
        "finished sample not presented at the output")

endmodule

`default_nettype wire

// File: sim/tb_he_if.sv
// Testbench build: the stream and configuration interfaces are compiled from the RTL folder
`timescale 1ns / 100ps

// File: sim/tb_top.sv
// Exciter testbench: directed and random samples checked against a Q.24 predictor
`timescale 1ns / 100ps

module tb_top;
    import he_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   n_errors = 0;

    he_in_if  in_if ();
    he_out_if out_if ();
    he_cfg_if cfg_if ();

    harmonic_exciter i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source),
        .i_cfg   (cfg_if.sink)
    );

    // Print one mismatch line and count it
    task automatic report(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        n_errors++;
    endtask

    // Exciter predictor plus queue of expected output samples
    class exciter_board;
        bit [15:0] pole = 16'd55240;
        bit [15:0] clip = 16'd511;
        bit [12:0] kcoef = 13'd512;
        bit [15:0] mix = 16'd128;
        longint    lp1 = 0;
        longint    lp2 = 0;
        logic signed [15:0] pending[$];

        function void write_reg(bit [7:0] idx, bit [15:0] val);
            case (idx)
                REG_LP_POLE:   pole = val;
                REG_CLIP_GAIN: clip = val;
                REG_SHAPER_K:  kcoef = val[12:0];
                REG_MIX_GAIN:  mix = val;
                default: ;
            endcase
        endfunction

        // Lowpass update; >>> on longint floors
        function longint hipass(longint inp, ref longint lp);
            longint p, acc, nl;
            p = pole;
            acc = (65536 - p) * inp + p * lp + 32768;
            nl = acc >>> 16;
            if (nl > 64'sd2147483647) nl = 64'sd2147483647;
            if (nl < -64'sd2147483648) nl = -64'sd2147483648;
            lp = nl;
            return inp - nl;
        endfunction

        function void note_sample(logic signed [15:0] s);
            longint x, hp, c, ax, den, num, sh, hp2, y, o;
            x = longint'(s) * 512;
            hp = hipass(x, lp1);
            c = (hp * longint'(clip)) >>> 8;
            if (c > 64'sd16777216) c = 64'sd16777216;
            if (c < -64'sd16777216) c = -64'sd16777216;
            ax = x < 0 ? -x : x;
            den = 64'sd16777216 + ((longint'(kcoef) * ax) >>> 8);
            num = (longint'(kcoef) + 256) * c * 65536;
            sh = num / den;
            hp2 = hipass(sh, lp2);
            y = x + ((hp2 * longint'(mix)) >>> 8);
            o = (y + 256) >>> 9;
            if (o > 32767) o = 32767;
            if (o < -32768) o = -32768;
            pending.push_back(o[15:0]);
        endfunction

        task check_sample(logic signed [15:0] got);
            logic signed [15:0] want;
            if (pending.size() == 0) begin
                report($sformatf("unexpected sample_out %0d", got));
                return;
            end
            want = pending.pop_front();
            if (got !== want)
                report($sformatf("sample_out %0d, expected %0d", got, want));
        endtask
    endclass

    exciter_board board = new();

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Time limit
    initial begin
        #400ms;
        $display("TEST FAILED");
        $finish;
    end

    // Monitors: input transfers feed the predictor, output transfers are checked
    always @(posedge i_clk) begin
        if (i_rst_n && in_if.valid && in_if.ready) board.note_sample(in_if.sample_in);
        if (i_rst_n && out_if.valid && out_if.ready) board.check_sample(out_if.sample_out);
    end

    // Receiver stalls at random
    initial begin
        int gap;
        out_if.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
            repeat (gap) begin
                out_if.ready <= 1'b0;
                @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            @(posedge i_clk iff out_if.valid);
        end
    end

    // valid stays high after the transfer; a call with gap > 0 or drain() drops it
    task automatic send_sample(input logic signed [15:0] s, input int gap);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.sample_in <= s;
        @(posedge i_clk iff in_if.ready);
    endtask

    // Register write; predictor updated at the transfer
    task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge i_clk iff cfg_if.ready);
        board.write_reg(idx, val);
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Let every expected result arrive, then the latency margin
    task automatic drain();
        in_if.valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic random_regs();
        write_reg(REG_LP_POLE,   ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom));
        write_reg(REG_CLIP_GAIN, 16'($urandom_range(0, 2) == 0 ? $urandom : $urandom_range(0, 2048)));
        write_reg(REG_SHAPER_K,  ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                              : 16'($urandom_range(0, 4608)));
        write_reg(REG_MIX_GAIN,  16'($urandom_range(0, 2) == 0 ? $urandom : $urandom_range(0, 1024)));
    endtask

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'($urandom_range(0, 255)) - 16'sd128;
            default: return 16'($urandom);
        endcase
    endfunction

    // Stimulus
    initial begin
        logic signed [15:0] dir_list[] = '{16'sh0000, 16'sh7FFF, 16'sh8000, 16'sh0001,
                                           16'shFFFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000,
                                           16'sh8000, 16'sh4000, 16'shC000};
        i_rst_n = 1'b0;
        in_if.valid <= 1'b0;
        in_if.sample_in <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= '0;
        cfg_if.data <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset settings, then extremes of every register
        foreach (dir_list[i]) send_sample(dir_list[i], 0);
        drain();
        write_reg(REG_LP_POLE, 16'hFFFF);
        write_reg(REG_CLIP_GAIN, 16'hFFFF);
        write_reg(REG_SHAPER_K, 16'h1FFF);   // above the nominal maximum
        write_reg(REG_MIX_GAIN, 16'hFFFF);
        write_reg(8'd200, 16'h1234);         // unknown index, ignored
        foreach (dir_list[i]) send_sample(dir_list[i], 1);
        drain();
        write_reg(REG_LP_POLE, 16'h0000);
        write_reg(REG_CLIP_GAIN, 16'h0000);
        write_reg(REG_SHAPER_K, 16'd4608);
        write_reg(REG_MIX_GAIN, 16'h0000);
        for (int i = 0; i < 4; i++) send_sample(dir_list[i], 0);
        drain();

        // Random phases with new settings between them
        for (int ph = 0; ph < 15; ph++) begin
            random_regs();
            for (int i = 0; i < 130; i++)
                send_sample(rand_sample(),
                            ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8));
            if (ph == 7) begin
                // sender holds off until all results are in
                in_if.valid <= 1'b0;
                @(posedge i_clk);
                while (board.pending.size() != 0) @(posedge i_clk);
                send_sample(rand_sample(), 0);
            end
            drain();
        end

        if (n_errors == 0 && board.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
